>>> rtl/ecp_pkg.sv
// shared types, constants and helper functions of the encoder speed controller
package ecp_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int WHEELS      = 2;
    localparam int WHEEL_W     = 1;
    localparam int SETPOINT_W  = 12;
    localparam int GAIN_W      = 16;
    localparam int SPEED_W     = 16;
    localparam int DUTY_W      = 7;
    localparam int CMP_W       = 12;

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_LSB = 2;
    localparam logic [PADDR_W-REG_IDX_LSB-1:0] REG_SPEED_GAIN = 1'b0;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // delta*K/10500 reduces to delta*NUM/DEN, the divide by DEN is a reciprocal multiply
    localparam longint unsigned SCALE_DIV   = 10500;
    localparam longint unsigned SCALE_A     = 60000;
    localparam longint unsigned SCALE_B     = 30000;
    localparam longint unsigned SCALE_GCD   = 1500;
    localparam longint unsigned NUM_A       = SCALE_A / SCALE_GCD;
    localparam longint unsigned NUM_B       = SCALE_B / SCALE_GCD;
    localparam longint unsigned DEN         = SCALE_DIV / SCALE_GCD;
    localparam int              RECIP_SHIFT = COUNT_WIDTH + 8;
    localparam longint unsigned RECIP       = ((64'd1 << RECIP_SHIFT) + DEN - 1) / DEN;
    localparam longint unsigned MUL_A       = NUM_A * RECIP;
    localparam longint unsigned MUL_B       = NUM_B * RECIP;
    localparam int              MUL_W       = $clog2(MUL_A + 1);
    localparam int              PROD_W      = COUNT_WIDTH + MUL_W;
    localparam int              RAW_W       = PROD_W - RECIP_SHIFT;

    localparam logic [MUL_W-1:0] LANE_MUL [WHEELS] = '{MUL_W'(MUL_A), MUL_W'(MUL_B)};

    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    localparam int ERR_W  = SPEED_W + 2;
    localparam int TERM_W = GAIN_W + 1 + ERR_W;
    localparam int ACC_W  = TERM_W + 1;
    localparam int FRAC_W = 10;

    localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd99;
    localparam logic [DUTY_W-1:0] DUTY_FLOOR = 7'd1;
    localparam logic [CMP_W-1:0]  CMP_TOP    = 12'd2499;
    localparam logic [CMP_W-1:0]  CMP_STEP   = 12'd24;

    typedef struct packed {
        logic                  op;
        logic                  wheel;
        logic                  direction_level;
        logic [SETPOINT_W-1:0] setpoint_a;
        logic [SETPOINT_W-1:0] setpoint_b;
    } ecp_in_t;

    typedef struct packed {
        logic [CMP_W-1:0]   compare_a;
        logic [CMP_W-1:0]   compare_b;
        logic [DUTY_W-1:0]  duty_a;
        logic [DUTY_W-1:0]  duty_b;
        logic [SPEED_W-1:0] speed_a;
        logic [SPEED_W-1:0] speed_b;
    } ecp_out_t;

    typedef struct packed {
        logic adv;
        logic take;
    } ecp_ctrl_t;

    typedef struct packed {
        logic                   valid;
        logic [COUNT_WIDTH-1:0] pos_a;
        logic [COUNT_WIDTH-1:0] pos_b;
        logic [SETPOINT_W-1:0]  setpoint_a;
        logic [SETPOINT_W-1:0]  setpoint_b;
    } ecp_sample_t;

    function automatic logic [CMP_W-1:0] cmp_of_duty(input logic [DUTY_W-1:0] d);
        return CMP_TOP - CMP_STEP * CMP_W'(d);
    endfunction

    // round half away from zero, then clamp to the duty range
    function automatic logic [DUTY_W-1:0] round_clamp(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-1:0]  mag;
        logic [ACC_W-1:0]  q;
        logic [DUTY_W-1:0] d;
        mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        q   = (mag + (ACC_W'(1) << (FRAC_W - 1))) >> FRAC_W;
        if (acc[ACC_W-1]) begin
            d = DUTY_FLOOR;
        end else if (q >= ACC_W'(DUTY_MAX)) begin
            d = DUTY_MAX;
        end else if (q == '0) begin
            d = DUTY_FLOOR;
        end else begin
            d = q[DUTY_W-1:0];
        end
        return d;
    endfunction

endpackage

>>> rtl/ecp_cnt_unit.sv
// position count memory with read-modify-write of edge requests and forwarding
module ecp_cnt_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  ecp_pkg::ecp_ctrl_t  ctrl,
    input  ecp_pkg::ecp_in_t    req,
    output ecp_pkg::ecp_sample_t sample
);
    import ecp_pkg::*;

    localparam logic [WHEEL_W-1:0] RD_ADDR1 = WHEEL_W'(1);

    logic [COUNT_WIDTH-1:0] cnt_mem [WHEELS];
    logic [WHEELS-1:0]      cnt_val_reg;

    logic [COUNT_WIDTH-1:0] rd0_reg;
    logic [COUNT_WIDTH-1:0] rd1_reg;
    logic                   s1_valid_reg;
    ecp_in_t                s1_req_reg;
    logic                   byp_valid_reg;
    logic [WHEEL_W-1:0]     byp_addr_reg;
    logic [COUNT_WIDTH-1:0] byp_data_reg;

    logic [WHEEL_W-1:0]     rd_addr0;
    logic [WHEEL_W-1:0]     s1_addr0;
    logic [COUNT_WIDTH-1:0] cur0;
    logic [COUNT_WIDTH-1:0] cur1;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic                   wr_en;

    assign rd_addr0 = (req.op == OP_TICK) ? '0 : req.wheel;
    assign s1_addr0 = (s1_req_reg.op == OP_TICK) ? '0 : s1_req_reg.wheel;

    assign cur0 = (byp_valid_reg && byp_addr_reg == s1_addr0) ? byp_data_reg : rd0_reg;
    assign cur1 = (byp_valid_reg && byp_addr_reg == RD_ADDR1) ? byp_data_reg : rd1_reg;

    assign cnt_next = s1_req_reg.direction_level ? cur0 + 1'b1 : cur0 - 1'b1;
    assign wr_en    = ctrl.adv && s1_valid_reg && (s1_req_reg.op == OP_EDGE);

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            rd0_reg      <= cnt_val_reg[rd_addr0] ? cnt_mem[rd_addr0] : '0;
            rd1_reg      <= cnt_val_reg[RD_ADDR1] ? cnt_mem[RD_ADDR1] : '0;
            s1_req_reg   <= req;
            byp_addr_reg <= s1_req_reg.wheel;
            byp_data_reg <= cnt_next;
        end
        if (wr_en) begin
            cnt_mem[s1_req_reg.wheel] <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            cnt_val_reg   <= '0;
        end else if (ctrl.adv) begin
            s1_valid_reg  <= ctrl.take;
            byp_valid_reg <= wr_en;
            if (wr_en) begin
                cnt_val_reg[s1_req_reg.wheel] <= 1'b1;
            end
        end
    end

    assign sample.valid      = s1_valid_reg && (s1_req_reg.op == OP_TICK);
    assign sample.pos_a      = cur0;
    assign sample.pos_b      = cur1;
    assign sample.setpoint_a = s1_req_reg.setpoint_a;
    assign sample.setpoint_b = s1_req_reg.setpoint_b;

endmodule

>>> rtl/ecp_tick_pipe.sv
// per-wheel tick pipeline: count delta, speed scaling, error, gain and duty update
module ecp_tick_pipe (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ecp_pkg::ecp_ctrl_t      ctrl,
    input  ecp_pkg::ecp_sample_t    sample,
    input  logic [ecp_pkg::GAIN_W-1:0] gain,
    output logic                    res_valid,
    output ecp_pkg::ecp_out_t       res
);
    import ecp_pkg::*;

    logic [COUNT_WIDTH-1:0] last_reg [WHEELS];
    logic [DUTY_W-1:0]      duty_reg [WHEELS];

    logic                   s2_valid_reg;
    logic [COUNT_WIDTH-1:0] delta_reg [WHEELS];
    logic [SETPOINT_W-1:0]  s2_sp_reg [WHEELS];

    logic                   s3_valid_reg;
    logic [PROD_W-1:0]      prod_reg [WHEELS];
    logic [SETPOINT_W-1:0]  s3_sp_reg [WHEELS];

    logic                   s4_valid_reg;
    logic signed [ERR_W-1:0] err_reg [WHEELS];
    logic [SPEED_W-1:0]     s4_speed_reg [WHEELS];

    logic                   s5_valid_reg;
    logic signed [TERM_W-1:0] term_reg [WHEELS];
    logic [SPEED_W-1:0]     s5_speed_reg [WHEELS];

    logic [COUNT_WIDTH-1:0] pos [WHEELS];
    logic [SETPOINT_W-1:0]  sp [WHEELS];
    logic [COUNT_WIDTH-1:0] diff [WHEELS];
    logic [COUNT_WIDTH-1:0] delta_next [WHEELS];
    logic [PROD_W-1:0]      prod_next [WHEELS];
    logic [RAW_W-1:0]       raw [WHEELS];
    logic [SPEED_W-1:0]     speed_next [WHEELS];
    logic signed [ERR_W-1:0] err_next [WHEELS];
    logic signed [TERM_W-1:0] term_next [WHEELS];
    logic signed [ACC_W-1:0] acc [WHEELS];
    logic [DUTY_W-1:0]      duty_next [WHEELS];

    assign pos[0] = sample.pos_a;
    assign pos[1] = sample.pos_b;
    assign sp[0]  = sample.setpoint_a;
    assign sp[1]  = sample.setpoint_b;

    always_comb begin
        for (int i = 0; i < WHEELS; i++) begin
            diff[i]       = pos[i] - last_reg[i];
            delta_next[i] = diff[i][COUNT_WIDTH-1] ? -diff[i] : diff[i];
            prod_next[i]  = PROD_W'(delta_reg[i]) * PROD_W'(LANE_MUL[i]);
            raw[i]        = prod_reg[i][PROD_W-1:RECIP_SHIFT];
            speed_next[i] = (raw[i] > RAW_W'(SPEED_MAX)) ? SPEED_MAX : raw[i][SPEED_W-1:0];
            err_next[i]   = $signed(ERR_W'(s3_sp_reg[i])) - $signed(ERR_W'(speed_next[i]));
            term_next[i]  = TERM_W'($signed({1'b0, gain})) * TERM_W'(err_reg[i]);
            acc[i]        = $signed(ACC_W'({duty_reg[i], FRAC_W'(0)})) + ACC_W'(term_reg[i]);
            duty_next[i]  = round_clamp(acc[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv) begin
            for (int i = 0; i < WHEELS; i++) begin
                delta_reg[i]    <= delta_next[i];
                s2_sp_reg[i]    <= sp[i];
                prod_reg[i]     <= prod_next[i];
                s3_sp_reg[i]    <= s2_sp_reg[i];
                err_reg[i]      <= err_next[i];
                s4_speed_reg[i] <= speed_next[i];
                term_reg[i]     <= term_next[i];
                s5_speed_reg[i] <= s4_speed_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            for (int i = 0; i < WHEELS; i++) begin
                last_reg[i] <= '0;
                duty_reg[i] <= '0;
            end
        end else if (ctrl.adv) begin
            s2_valid_reg <= sample.valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            for (int i = 0; i < WHEELS; i++) begin
                if (sample.valid) begin
                    last_reg[i] <= pos[i];
                end
                if (s5_valid_reg) begin
                    duty_reg[i] <= duty_next[i];
                end
            end
        end
    end

    assign res_valid     = s5_valid_reg;
    assign res.compare_a = cmp_of_duty(duty_next[0]);
    assign res.compare_b = cmp_of_duty(duty_next[1]);
    assign res.duty_a    = duty_next[0];
    assign res.duty_b    = duty_next[1];
    assign res.speed_a   = s5_speed_reg[0];
    assign res.speed_b   = s5_speed_reg[1];

endmodule

>>> rtl/encoder_speed_p_controller.sv
// top level of the two-wheel encoder speed controller with proportional duty update
// a tick request reaches m_valid through the s1, s2 to s5 and m_valid_reg registers
// throughput: one request per cycle while s_ready is high, edges and ticks alike, set by
// the single write port of the count memory and the one-stage read-modify-write around it
// the pipeline holds only while a finished tick result waits behind an untaken one
// reset: synchronous active-low aresetn clears counts, samples, duties and gain
module encoder_speed_p_controller (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ecp_pkg::ecp_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ecp_pkg::ecp_out_t                m_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ecp_pkg::PADDR_W-1:0]      paddr,
    input  logic [ecp_pkg::PDATA_W-1:0]      pwdata,
    output logic [ecp_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);
    import ecp_pkg::*;

    ecp_ctrl_t          ctrl;
    ecp_sample_t        sample;
    ecp_out_t           res;
    logic               res_valid;

    logic               m_valid_reg;
    logic               m_valid_next;
    ecp_out_t           m_data_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [GAIN_W-1:0]  gain_next;
    logic               gain_sel;

    assign ctrl.adv  = !(res_valid && m_valid_reg && !m_ready);
    assign ctrl.take = s_valid && ctrl.adv;
    assign s_ready   = ctrl.adv;

    ecp_cnt_unit u_cnt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .req     (s_data),
        .sample  (sample)
    );

    ecp_tick_pipe u_tick (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .sample    (sample),
        .gain      (gain_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.adv && res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.adv && res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // register file
    assign gain_sel  = (paddr[PADDR_W-1:REG_IDX_LSB] == REG_SPEED_GAIN);
    assign gain_next = (psel && penable && pwrite && gain_sel) ? pwdata[GAIN_W-1:0] : gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= '0;
        end else begin
            gain_reg <= gain_next;
        end
    end

    assign prdata = gain_sel ? PDATA_W'(gain_reg) : '0;
    assign pready = 1'b1;

endmodule

>>> rtl/ecp_checker.sv
// port-level checks of the encoder speed controller and their bind
module ecp_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input ecp_pkg::ecp_out_t    m_data
);
    import ecp_pkg::*;

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request refused with empty output");

    a_duty_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.duty_a >= DUTY_FLOOR) && (m_data.duty_a <= DUTY_MAX)
                 && (m_data.duty_b >= DUTY_FLOOR) && (m_data.duty_b <= DUTY_MAX)
                 && (m_data.compare_a == cmp_of_duty(m_data.duty_a))
                 && (m_data.compare_b == cmp_of_duty(m_data.duty_b)))
        else $error("duty or compare out of line");

endmodule

bind encoder_speed_p_controller ecp_checker u_ecp_checker (.*);
